/* design/pvm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pvm_pkg
// shared types and constants of the pike vm regex matcher
// ---------------------------------------------------------------------------
package pvm_pkg;

	localparam logic [3:0] OP_RUNE   = 4'd0;
	localparam logic [3:0] OP_ANY    = 4'd1;
	localparam logic [3:0] OP_CLASS  = 4'd2;
	localparam logic [3:0] OP_NOTNL  = 4'd3;
	localparam logic [3:0] OP_BOL    = 4'd4;
	localparam logic [3:0] OP_EOL    = 4'd5;
	localparam logic [3:0] OP_JMP    = 4'd6;
	localparam logic [3:0] OP_SPLIT  = 4'd7;
	localparam logic [3:0] OP_SAVE   = 4'd8;
	localparam logic [3:0] OP_UNSAVE = 4'd9;

	localparam logic [20:0] NEWLINE = 21'd10;

	localparam logic [1:0] REG_SUBMATCH = 2'd0;
	localparam logic [1:0] REG_START    = 2'd1;
	localparam logic [1:0] REG_LENGTH   = 2'd2;

	typedef struct packed {
		logic        action;
		logic [7:0]  address;
		logic [3:0]  opcode;
		logic [20:0] range_low;
		logic [20:0] range_high;
		logic [7:0]  target_first;
		logic [7:0]  target_second;
		logic [3:0]  group_index;
		logic [20:0] code_point;
	} req_t;

	typedef struct packed {
		logic [3:0]  report_group;
		logic        matched;
		logic        start_valid;
		logic [31:0] start_pos;
		logic        end_valid;
		logic [31:0] end_pos;
		logic        pool_overflow;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [7:0]  target_first;
		logic [7:0]  target_second;
		logic [3:0]  group_index;
		logic [20:0] range_low;
		logic [20:0] range_high;
	} prog_word_t;

endpackage
`default_nettype wire

/* design/pvm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pvm_ram
// generic simple dual port ram, one write port, registered read
// ---------------------------------------------------------------------------
module pvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* design/pike_vm_regex_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pike_vm_regex_matcher
// pike vm regex executor with submatch capture, program and captures in ram
// ---------------------------------------------------------------------------
// a character is worked through instruction by instruction and class range
// by range over the single program ram port; a split copies the captures and
// a first match reads them group by group, and a new start thread clears them
// a report gives one result per cycle while the result side does not stall
// reset clears search state, visited marks and thread lists, resets registers
// ---------------------------------------------------------------------------
module pike_vm_regex_matcher #(
	parameter int PROGRAM_DEPTH = 256,
	parameter int THREAD_COUNT  = 32,
	parameter int GROUP_COUNT   = 10,
	parameter int POSITION_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [8:0]    cfg_data,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pvm_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_stall,
	output pvm_pkg::res_t      res
);

	import pvm_pkg::*;

	localparam int AW        = $clog2(PROGRAM_DEPTH);
	localparam int PC_W      = (AW + 1 > 9) ? AW + 1 : 9;
	localparam int TW        = $clog2(THREAD_COUNT);
	localparam int CNTW      = TW + 1;
	localparam int GIW       = GROUP_COUNT > 1 ? $clog2(GROUP_COUNT) : 1;
	localparam int GW        = $clog2(GROUP_COUNT + 1);
	localparam int KW        = GW > 4 ? GW : 4;
	localparam int CAP_DEPTH = THREAD_COUNT * GROUP_COUNT;
	localparam int CAW       = $clog2(CAP_DEPTH);
	localparam int PW        = POSITION_BITS;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LIST   = 4'd1;
	localparam logic [3:0] S_SEED   = 4'd2;
	localparam logic [3:0] S_FETCH  = 4'd3;
	localparam logic [3:0] S_EXEC   = 4'd4;
	localparam logic [3:0] S_COPY   = 4'd5;
	localparam logic [3:0] S_MATCH  = 4'd6;
	localparam logic [3:0] S_RETIRE = 4'd7;
	localparam logic [3:0] S_FINISH = 4'd8;
	localparam logic [3:0] S_REPORT = 4'd9;

	function automatic logic [AW-1:0] addr_mod(input logic [7:0] a);
		int v;
		v = int'(a);
		for (int k = 7; k >= 0; k--) begin
			if (v >= (PROGRAM_DEPTH << k)) begin
				v = v - (PROGRAM_DEPTH << k);
			end
		end
		return AW'(v);
	endfunction

	function automatic logic [CAW-1:0] cap_addr(input logic [TW-1:0] t,
			input logic [GIW-1:0] g);
		return CAW'(int'(t) * GROUP_COUNT + int'(g));
	endfunction

	logic [3:0]      state_q;
	logic [3:0]      sub_q;
	logic [7:0]      start_q;
	logic [8:0]      plen_q;

	logic [20:0]     r_q;
	logic [20:0]     prev_q;
	logic [PW-1:0]   pos_q;
	logic            match_q;
	logic            done_q;
	logic            ovf_q;
	logic            firstm_q;
	logic            seeding_q;
	logic            consume_q;
	logic            class_q;

	logic [TW-1:0]   t_q;
	logic [TW-1:0]   c_q;
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] cls_q;
	logic [GW-1:0]   cnt_q;
	logic [CNTW-1:0] i_q;
	logic [KW-1:0]   k_q;

	logic                     bank_q;
	logic [CNTW-1:0]          cur_cnt_q;
	logic [CNTW-1:0]          nxt_cnt_q;
	logic [TW-1:0]            list_q [2][THREAD_COUNT];
	logic [CNTW-1:0]          free_cnt_q;
	logic [TW-1:0]            free_q [THREAD_COUNT];
	logic [CNTW-1:0]          pend_cnt_q;
	logic [TW-1:0]            pend_q [THREAD_COUNT];
	logic [PC_W-1:0]          tpc_q [THREAD_COUNT];
	logic [PROGRAM_DEPTH-1:0] visited_q;
	logic [PW:0]              best_s_q [GROUP_COUNT];
	logic [PW:0]              best_e_q [GROUP_COUNT];

	logic            res_valid_q;
	res_t            res_q;

	logic            prog_we;
	logic [AW-1:0]   prog_waddr;
	prog_word_t      prog_wdata;
	logic [AW-1:0]   prog_raddr;
	logic [65:0]     prog_rdata;
	prog_word_t      w;

	logic            st_we;
	logic            en_we;
	logic [CAW-1:0]  st_waddr;
	logic [CAW-1:0]  en_waddr;
	logic [PW:0]     st_wdata;
	logic [PW:0]     en_wdata;
	logic [CAW-1:0]  cap_raddr;
	logic [PW:0]     st_rdata;
	logic [PW:0]     en_rdata;

	logic [PC_W-1:0] len;
	logic [PC_W-1:0] cls_next;
	logic [GW-1:0]   cntm1;
	logic            grp_ok;
	logic            accept;
	logic            new_search;
	logic [KW-1:0]   groups;
	logic [KW-1:0]   n_res;
	logic            use_best;
	logic [PW:0]     rep_s;
	logic [PW:0]     rep_e;
	logic            report_load;
	logic            report_last;
	logic [TW-1:0]   pend_top;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign len = (PC_W'(plen_q) > PC_W'(PROGRAM_DEPTH)) ? PC_W'(PROGRAM_DEPTH)
		: PC_W'(plen_q);
	assign cls_next = cls_q + PC_W'(1);
	assign cntm1    = cnt_q - GW'(1);
	assign w        = prog_word_t'(prog_rdata);
	assign grp_ok   = 6'(w.group_index) < 6'(GROUP_COUNT);
	assign pend_top = pend_q[TW'(pend_cnt_q - CNTW'(1))];

	// program memory
	assign prog_we    = accept && !req.action;
	assign prog_waddr = addr_mod(req.address);
	assign prog_wdata = '{opcode: req.opcode, target_first: req.target_first,
		target_second: req.target_second, group_index: req.group_index,
		range_low: req.range_low, range_high: req.range_high};
	assign prog_raddr = (state_q == S_EXEC) ? cls_next[AW-1:0] : pc_q[AW-1:0];

	pvm_ram #(.WIDTH(66), .DEPTH(PROGRAM_DEPTH)) u_prog (
		.clk   (clk),
		.we    (prog_we),
		.waddr (prog_waddr),
		.wdata (prog_wdata),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	// capture memories
	always_comb begin
		st_we     = 1'b0;
		en_we     = 1'b0;
		st_waddr  = cap_addr(t_q, GIW'(w.group_index));
		en_waddr  = cap_addr(t_q, GIW'(w.group_index));
		st_wdata  = {1'b1, pos_q};
		en_wdata  = {1'b1, pos_q};
		cap_raddr = cap_addr(t_q, cnt_q[GIW-1:0]);
		case (state_q)
			S_SEED: begin
				st_we    = 1'b1;
				en_we    = 1'b1;
				st_waddr = cap_addr(t_q, cnt_q[GIW-1:0]);
				en_waddr = cap_addr(t_q, cnt_q[GIW-1:0]);
				st_wdata = '0;
				en_wdata = '0;
			end
			S_COPY: begin
				st_we    = (cnt_q != '0);
				en_we    = (cnt_q != '0);
				st_waddr = cap_addr(c_q, cntm1[GIW-1:0]);
				en_waddr = cap_addr(c_q, cntm1[GIW-1:0]);
				st_wdata = st_rdata;
				en_wdata = en_rdata;
			end
			S_EXEC: begin
				if (!class_q && w.opcode == OP_SAVE && grp_ok) begin
					st_we = 1'b1;
				end
				if (!class_q && w.opcode == OP_UNSAVE && w.group_index != 4'd0
						&& grp_ok) begin
					en_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	pvm_ram #(.WIDTH(PW + 1), .DEPTH(CAP_DEPTH)) u_starts (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (cap_raddr),
		.rdata (st_rdata)
	);

	pvm_ram #(.WIDTH(PW + 1), .DEPTH(CAP_DEPTH)) u_ends (
		.clk   (clk),
		.we    (en_we),
		.waddr (en_waddr),
		.wdata (en_wdata),
		.raddr (cap_raddr),
		.rdata (en_rdata)
	);

	// report
	assign groups = (KW'(sub_q) > KW'(GROUP_COUNT)) ? KW'(GROUP_COUNT) : KW'(sub_q);
	assign n_res  = (groups == '0) ? KW'(1) : groups;
	assign use_best = (k_q < groups) && match_q;
	assign rep_s  = use_best ? best_s_q[k_q[GIW-1:0]] : '0;
	assign rep_e  = use_best ? best_e_q[k_q[GIW-1:0]] : '0;
	assign report_load = (state_q == S_REPORT) && (!res_valid_q || !res_stall);
	assign report_last = (k_q == n_res - KW'(1));

	assign new_search = (accept && req.action && done_q && req.code_point == '0)
		|| (report_load && report_last && r_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sub_q       <= '0;
			start_q     <= '0;
			plen_q      <= 9'd256;
			r_q         <= '0;
			prev_q      <= '0;
			pos_q       <= '0;
			match_q     <= 1'b0;
			done_q      <= 1'b0;
			ovf_q       <= 1'b0;
			firstm_q    <= 1'b0;
			seeding_q   <= 1'b0;
			consume_q   <= 1'b0;
			class_q     <= 1'b0;
			cnt_q       <= '0;
			i_q         <= '0;
			k_q         <= '0;
			bank_q      <= 1'b0;
			cur_cnt_q   <= '0;
			nxt_cnt_q   <= '0;
			pend_cnt_q  <= '0;
			free_cnt_q  <= CNTW'(THREAD_COUNT);
			for (int j = 0; j < THREAD_COUNT; j++) begin
				free_q[j] <= TW'(j);
			end
			visited_q   <= '0;
			for (int j = 0; j < GROUP_COUNT; j++) begin
				best_s_q[j][PW] <= 1'b0;
				best_e_q[j][PW] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !report_load) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SUBMATCH: sub_q   <= cfg_data[3:0];
					REG_START:    start_q <= cfg_data[7:0];
					REG_LENGTH:   plen_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept && req.action && !done_q) begin
						r_q       <= req.code_point;
						visited_q <= '0;
						nxt_cnt_q <= '0;
						i_q       <= '0;
						firstm_q  <= 1'b1;
						seeding_q <= 1'b0;
						state_q   <= S_LIST;
					end
				end
				S_LIST: begin
					cnt_q <= '0;
					if (i_q < cur_cnt_q) begin
						t_q     <= list_q[bank_q][i_q[TW-1:0]];
						pc_q    <= tpc_q[list_q[bank_q][i_q[TW-1:0]]];
						i_q     <= i_q + CNTW'(1);
						state_q <= S_FETCH;
					end else if (!match_q) begin
						if (free_cnt_q == '0) begin
							ovf_q   <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							t_q        <= free_q[TW'(free_cnt_q - CNTW'(1))];
							tpc_q[free_q[TW'(free_cnt_q - CNTW'(1))]] <= PC_W'(start_q);
							pc_q       <= PC_W'(start_q);
							free_cnt_q <= free_cnt_q - CNTW'(1);
							seeding_q  <= 1'b1;
							state_q    <= S_SEED;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_SEED: begin
					cnt_q <= cnt_q + GW'(1);
					if (cnt_q == GW'(GROUP_COUNT - 1)) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (pc_q >= len || visited_q[pc_q[AW-1:0]]) begin
						consume_q <= 1'b0;
						state_q   <= S_RETIRE;
					end else begin
						visited_q[pc_q[AW-1:0]] <= 1'b1;
						cls_q   <= pc_q;
						class_q <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					cnt_q <= '0;
					if (class_q || w.opcode == OP_CLASS) begin
						if (r_q >= w.range_low && r_q <= w.range_high) begin
							consume_q <= 1'b1;
							pc_q      <= PC_W'(w.target_first);
							class_q   <= 1'b0;
							state_q   <= S_RETIRE;
						end else if (r_q >= w.range_low && cls_next < len) begin
							cls_q   <= cls_next;
							class_q <= 1'b1;
						end else begin
							consume_q <= 1'b0;
							class_q   <= 1'b0;
							state_q   <= S_RETIRE;
						end
					end else begin
						case (w.opcode)
							OP_RUNE: begin
								consume_q <= (r_q == w.range_low);
								pc_q      <= pc_q + PC_W'(1);
								state_q   <= S_RETIRE;
							end
							OP_ANY: begin
								consume_q <= 1'b1;
								pc_q      <= pc_q + PC_W'(1);
								state_q   <= S_RETIRE;
							end
							OP_NOTNL: begin
								if (r_q != NEWLINE) begin
									pc_q    <= pc_q + PC_W'(1);
									state_q <= S_FETCH;
								end else begin
									consume_q <= 1'b0;
									state_q   <= S_RETIRE;
								end
							end
							OP_BOL: begin
								if (prev_q == '0 || prev_q == NEWLINE) begin
									pc_q    <= pc_q + PC_W'(1);
									state_q <= S_FETCH;
								end else begin
									consume_q <= 1'b0;
									state_q   <= S_RETIRE;
								end
							end
							OP_EOL: begin
								pc_q <= pc_q + PC_W'(1);
								if (r_q == '0) begin
									state_q <= S_FETCH;
								end else begin
									consume_q <= (r_q == NEWLINE);
									state_q   <= S_RETIRE;
								end
							end
							OP_JMP: begin
								pc_q    <= PC_W'(w.target_first);
								state_q <= S_FETCH;
							end
							OP_SPLIT: begin
								pc_q <= PC_W'(w.target_first);
								if (free_cnt_q == '0 || pend_cnt_q >= CNTW'(THREAD_COUNT)) begin
									ovf_q   <= 1'b1;
									state_q <= S_FETCH;
								end else begin
									c_q        <= free_q[TW'(free_cnt_q - CNTW'(1))];
									tpc_q[free_q[TW'(free_cnt_q - CNTW'(1))]] <=
										PC_W'(w.target_second);
									pend_q[TW'(pend_cnt_q)] <=
										free_q[TW'(free_cnt_q - CNTW'(1))];
									pend_cnt_q <= pend_cnt_q + CNTW'(1);
									free_cnt_q <= free_cnt_q - CNTW'(1);
									state_q    <= S_COPY;
								end
							end
							OP_SAVE: begin
								pc_q    <= pc_q + PC_W'(1);
								state_q <= S_FETCH;
							end
							OP_UNSAVE: begin
								if (w.group_index == 4'd0) begin
									consume_q <= 1'b0;
									if (firstm_q) begin
										firstm_q <= 1'b0;
										match_q  <= 1'b1;
										state_q  <= S_MATCH;
									end else begin
										state_q <= S_RETIRE;
									end
								end else begin
									pc_q    <= pc_q + PC_W'(1);
									state_q <= S_FETCH;
								end
							end
							default: begin
								consume_q <= 1'b0;
								state_q   <= S_RETIRE;
							end
						endcase
					end
				end
				S_COPY: begin
					cnt_q <= cnt_q + GW'(1);
					if (cnt_q == GW'(GROUP_COUNT)) begin
						state_q <= S_FETCH;
					end
				end
				S_MATCH: begin
					cnt_q <= cnt_q + GW'(1);
					if (cnt_q != '0) begin
						best_s_q[cntm1[GIW-1:0]] <= st_rdata;
						best_e_q[cntm1[GIW-1:0]] <= (cntm1 == '0) ? {1'b1, pos_q}
							: en_rdata;
					end
					if (cnt_q == GW'(GROUP_COUNT)) begin
						state_q <= S_RETIRE;
					end
				end
				S_RETIRE: begin
					if (consume_q && nxt_cnt_q < CNTW'(THREAD_COUNT)) begin
						tpc_q[t_q] <= pc_q;
						list_q[~bank_q][nxt_cnt_q[TW-1:0]] <= t_q;
						nxt_cnt_q <= nxt_cnt_q + CNTW'(1);
					end else if (free_cnt_q < CNTW'(THREAD_COUNT)) begin
						free_q[free_cnt_q[TW-1:0]] <= t_q;
						free_cnt_q <= free_cnt_q + CNTW'(1);
					end
					if (pend_cnt_q == '0) begin
						state_q <= seeding_q ? S_FINISH : S_LIST;
					end else begin
						t_q        <= pend_top;
						pc_q       <= tpc_q[pend_top];
						pend_cnt_q <= pend_cnt_q - CNTW'(1);
						state_q    <= S_FETCH;
					end
				end
				S_FINISH: begin
					bank_q    <= ~bank_q;
					cur_cnt_q <= nxt_cnt_q;
					nxt_cnt_q <= '0;
					pos_q     <= pos_q + PW'(1);
					prev_q    <= r_q;
					k_q       <= '0;
					if ((match_q && nxt_cnt_q == '0) || r_q == '0) begin
						state_q <= S_REPORT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_REPORT: begin
					if (report_load) begin
						res_q.report_group  <= 4'(k_q);
						res_q.matched       <= match_q;
						res_q.start_valid   <= rep_s[PW];
						res_q.start_pos     <= rep_s[PW] ? 32'(rep_s[PW-1:0]) : '0;
						res_q.end_valid     <= rep_e[PW];
						res_q.end_pos       <= rep_e[PW] ? 32'(rep_e[PW-1:0]) : '0;
						res_q.pool_overflow <= ovf_q;
						res_q.last          <= report_last;
						res_valid_q         <= 1'b1;
						if (report_last) begin
							if (r_q != '0) begin
								done_q <= 1'b1;
							end
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + KW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (new_search) begin
				visited_q  <= '0;
				cur_cnt_q  <= '0;
				nxt_cnt_q  <= '0;
				free_cnt_q <= CNTW'(THREAD_COUNT);
				for (int j = 0; j < THREAD_COUNT; j++) begin
					free_q[j] <= TW'(j);
				end
				for (int j = 0; j < GROUP_COUNT; j++) begin
					best_s_q[j][PW] <= 1'b0;
					best_e_q[j][PW] <= 1'b0;
				end
				pos_q   <= '0;
				prev_q  <= '0;
				match_q <= 1'b0;
				done_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// every thread is either live or free between characters
	a_thread_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (free_cnt_q + cur_cnt_q == CNTW'(THREAD_COUNT)))
		else $error("thread count lost");

	a_pend_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST || state_q == S_FINISH) |-> (pend_cnt_q == '0))
		else $error("pending threads left behind");

	a_match_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(match_q) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_REPORT))
		else $error("match flag cleared mid search");

endmodule
`default_nettype wire

/* test/pvm_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pvm_checker
// Watches the request, result and register ports of the regex matcher. It
// keeps its own copy of the program, the thread pool and the captures, and
// works out the report that each character should give. Every result is
// compared field by field with the oldest expected result.
// ---------------------------------------------------------------------------
module pvm_checker
	import pvm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire logic       req_valid,
	input  wire logic       req_stall,
	input  wire req_t       req,
	input  wire logic       res_valid,
	input  wire logic       res_stall,
	input  wire res_t       res,
	output int              errors,
	output int              outstanding
);

	localparam int DEPTH   = 256;
	localparam int THREADS = 32;
	localparam int GROUPS  = 10;

	logic [3:0]  w_op     [DEPTH];
	logic [7:0]  w_first  [DEPTH];
	logic [7:0]  w_second [DEPTH];
	logic [3:0]  w_group  [DEPTH];
	logic [20:0] w_lo     [DEPTH];
	logic [20:0] w_hi     [DEPTH];
	bit          seen     [DEPTH];

	int          tpc      [THREADS];
	int          cur      [THREADS];
	int          nxt      [THREADS];
	int          freel    [THREADS];
	int          ncur, nnext, nfree;
	logic [32:0] tstart   [THREADS][GROUPS];
	logic [32:0] tend     [THREADS][GROUPS];
	logic [32:0] best_s   [GROUPS];
	logic [32:0] best_e   [GROUPS];
	logic [31:0] cpos;
	logic [20:0] prev_cp;
	bit          f_match, f_done, f_ovf, match_open;

	logic [3:0]  n_groups;
	logic [7:0]  entry_pc;
	logic [8:0]  prog_len;

	res_t        report_q [$];

	function automatic void clear_search();
		for (int i = 0; i < DEPTH; i++) seen[i] = 0;
		ncur = 0;
		nnext = 0;
		for (int i = 0; i < THREADS; i++) freel[i] = i;
		nfree = THREADS;
		for (int g = 0; g < GROUPS; g++) begin
			best_s[g] = '0;
			best_e[g] = '0;
		end
		cpos = '0;
		prev_cp = '0;
		f_match = 0;
		f_done = 0;
		f_ovf = 0;
	endfunction

	// runs a thread and all threads split off from it, in priority order
	function automatic void run_tree(int t0, logic [20:0] r, logic [31:0] p);
		int pend [THREADS];
		int np, t, pc, newpc, c, fate, len;
		np = 0;
		t = t0;
		len = (prog_len < DEPTH) ? prog_len : DEPTH;
		forever begin
			pc = tpc[t];
			newpc = 0;
			fate = 0;
			while (fate == 0) begin
				if (pc >= len || seen[pc]) begin
					fate = 2;
					break;
				end
				seen[pc] = 1;
				case (w_op[pc])
					OP_RUNE: begin
						if (r == w_lo[pc]) begin
							fate = 1;
							newpc = pc + 1;
						end else fate = 2;
					end
					OP_ANY: begin
						fate = 1;
						newpc = pc + 1;
					end
					OP_CLASS: begin
						c = pc;
						fate = 2;
						while (c < len && r >= w_lo[c]) begin
							if (r <= w_hi[c]) begin
								fate = 1;
								newpc = w_first[c];
								break;
							end
							c++;
						end
					end
					OP_NOTNL: begin
						if (r != NEWLINE) pc++;
						else fate = 2;
					end
					OP_BOL: begin
						if (prev_cp == 0 || prev_cp == NEWLINE) pc++;
						else fate = 2;
					end
					OP_EOL: begin
						if (r == 0) pc++;
						else if (r == NEWLINE) begin
							fate = 1;
							newpc = pc + 1;
						end else fate = 2;
					end
					OP_JMP: pc = w_first[pc];
					OP_SPLIT: begin
						if (nfree == 0 || np >= THREADS) f_ovf = 1;
						else begin
							nfree--;
							c = freel[nfree];
							tpc[c] = w_second[pc];
							for (int g = 0; g < GROUPS; g++) begin
								tstart[c][g] = tstart[t][g];
								tend[c][g] = tend[t][g];
							end
							pend[np] = c;
							np++;
						end
						pc = w_first[pc];
					end
					OP_SAVE: begin
						if (w_group[pc] < GROUPS) tstart[t][w_group[pc]] = {1'b1, p};
						pc++;
					end
					OP_UNSAVE: begin
						if (w_group[pc] == 0) begin
							if (match_open) begin
								match_open = 0;
								f_match = 1;
								for (int g = 0; g < GROUPS; g++) begin
									best_s[g] = tstart[t][g];
									best_e[g] = tend[t][g];
								end
								best_e[0] = {1'b1, p};
							end
							fate = 2;
						end else begin
							if (w_group[pc] < GROUPS) tend[t][w_group[pc]] = {1'b1, p};
							pc++;
						end
					end
					default: fate = 2;
				endcase
			end
			if (fate == 1 && nnext < THREADS) begin
				tpc[t] = newpc;
				nxt[nnext] = t;
				nnext++;
			end else if (nfree < THREADS) begin
				freel[nfree] = t;
				nfree++;
			end
			if (np == 0) return;
			np--;
			t = pend[np];
		end
	endfunction

	function automatic void push_report();
		int cnt, n;
		res_t o;
		logic [32:0] s, e;
		cnt = (n_groups < GROUPS) ? n_groups : GROUPS;
		n = (cnt == 0) ? 1 : cnt;
		for (int k = 0; k < n; k++) begin
			s = '0;
			e = '0;
			if (k < cnt && f_match) begin
				s = best_s[k];
				e = best_e[k];
			end
			o.report_group  = k[3:0];
			o.matched       = f_match;
			o.start_valid   = s[32];
			o.start_pos     = s[32] ? s[31:0] : '0;
			o.end_valid     = e[32];
			o.end_pos       = e[32] ? e[31:0] : '0;
			o.pool_overflow = f_ovf;
			o.last          = (k + 1 == n);
			report_q.push_back(o);
		end
	endfunction

	function automatic void apply_request(req_t q);
		logic [20:0] r;
		logic [31:0] p;
		int t;
		if (!q.action) begin
			w_op[q.address]     = q.opcode;
			w_lo[q.address]     = q.range_low;
			w_hi[q.address]     = q.range_high;
			w_first[q.address]  = q.target_first;
			w_second[q.address] = q.target_second;
			w_group[q.address]  = q.group_index;
			return;
		end
		r = q.code_point;
		if (f_done) begin
			if (r == 0) clear_search();
			return;
		end
		p = cpos;
		for (int i = 0; i < DEPTH; i++) seen[i] = 0;
		nnext = 0;
		match_open = 1;
		for (int i = 0; i < ncur; i++) run_tree(cur[i], r, p);
		if (!f_match) begin
			if (nfree == 0) f_ovf = 1;
			else begin
				nfree--;
				t = freel[nfree];
				tpc[t] = entry_pc;
				for (int g = 0; g < GROUPS; g++) begin
					tstart[t][g] = '0;
					tend[t][g] = '0;
				end
				run_tree(t, r, p);
			end
		end
		for (int i = 0; i < THREADS; i++) cur[i] = nxt[i];
		ncur = nnext;
		nnext = 0;
		cpos = cpos + 1;
		prev_cp = r;
		if ((f_match && ncur == 0) || r == 0) begin
			push_report();
			if (r == 0) clear_search();
			else f_done = 1;
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endfunction

	function automatic void check_result(res_t got);
		res_t exp_r;
		if (report_q.size() == 0) begin
			$error("result with no request waiting: group %0d", got.report_group);
			errors++;
			return;
		end
		exp_r = report_q.pop_front();
		check_field("report_group", exp_r.report_group, got.report_group);
		check_field("matched", exp_r.matched, got.matched);
		check_field("start_valid", exp_r.start_valid, got.start_valid);
		check_field("start_pos", exp_r.start_pos, got.start_pos);
		check_field("end_valid", exp_r.end_valid, got.end_valid);
		check_field("end_pos", exp_r.end_pos, got.end_pos);
		check_field("pool_overflow", exp_r.pool_overflow, got.pool_overflow);
		check_field("last", exp_r.last, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_groups = '0;
			entry_pc = '0;
			prog_len = 9'd256;
			for (int i = 0; i < THREADS; i++) tpc[i] = 0;
			clear_search();
			report_q.delete();
		end else begin
			if (res_valid && !res_stall) check_result(res);
			if (cfg_we) begin
				case (cfg_index)
					REG_SUBMATCH: n_groups = cfg_data[3:0];
					REG_START:    entry_pc = cfg_data[7:0];
					REG_LENGTH:   prog_len = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall) apply_request(req);
		end
		outstanding = report_q.size();
	end

	initial begin
		errors = 0;
		outstanding = 0;
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives the regex matcher with program loads and texts under a series of
// register settings, with random gaps on both sides, a long result hold-off
// and a thread pool exhaustion case, and gives the verdict of the checker.
// ---------------------------------------------------------------------------
module tb;
	import pvm_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int SETTLE   = 3000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       res_valid;
	logic       res_stall;
	res_t       res;
	int         errors;
	int         outstanding;
	int         quiet_cycles;
	int         items_sent;
	bit         calm;
	bit         hold_req;

	pike_vm_regex_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	pvm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 0;
				res_stall <= 1'b0;
			end else begin
				res_stall <= !calm && ($urandom_range(0, 99) < 9);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("** pike_vm_regex_matcher: FAILED **");
			$finish;
		end
	end

	function automatic req_t noise();
		req_t q;
		q = {$urandom(), $urandom(), $urandom()};
		return q;
	endfunction

	function automatic logic [20:0] letter();
		case ($urandom_range(0, 4))
			0: return 21'h61;
			1: return 21'h62;
			2: return 21'h63;
			3: return NEWLINE;
			default: return 21'h64;
		endcase
	endfunction

	task automatic send(input req_t q);
		req <= q;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items_sent++;
		if (!calm && $urandom_range(0, 99) < 9) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic load_word(input int a, input logic [3:0] op, input logic [20:0] lo,
		input logic [20:0] hi, input logic [7:0] t1, input logic [7:0] t2,
		input logic [3:0] g);
		req_t q;
		q = noise();
		q.action = 1'b0;
		q.address = a[7:0];
		q.opcode = op;
		q.range_low = lo;
		q.range_high = hi;
		q.target_first = t1;
		q.target_second = t2;
		q.group_index = g;
		send(q);
	endtask

	task automatic send_char(input logic [20:0] cp);
		req_t q;
		q = noise();
		q.action = 1'b1;
		q.code_point = cp;
		send(q);
	endtask

	// all expected results in, then time for a request with no result to finish
	task automatic settle();
		req_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input int groups, input int entry, input int len);
		write_reg(REG_SUBMATCH, {5'($urandom()), 4'(groups)});
		write_reg(REG_START, {1'($urandom()), 8'(entry)});
		write_reg(REG_LENGTH, 9'(len));
	endtask

	task automatic random_program(input int len);
		logic [3:0] op;
		logic [20:0] lo;
		int lim;
		lim = (len > 256) ? 256 : len;
		for (int a = 0; a < lim; a++) begin
			if ($urandom_range(0, 99) < 5) op = 4'($urandom_range(10, 15));
			else op = 4'($urandom_range(0, 9));
			if (a == 0 && lim > 1) op = OP_SAVE;
			if (a == lim - 1 && lim > 1) op = OP_UNSAVE;
			lo = ($urandom_range(0, 9) == 0) ? 21'($urandom()) : letter();
			load_word(a, op, lo, lo + 21'($urandom_range(0, 2)),
				($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, lim - 1)),
				($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, lim - 1)),
				(a == 0 || a == lim - 1) ? 4'd0 :
				(($urandom_range(0, 19) == 0) ? 4'd15 : 4'($urandom_range(0, 11))));
		end
	endtask

	task automatic random_text();
		int n;
		n = $urandom_range(0, 7);
		for (int i = 0; i < n; i++)
			send_char(($urandom_range(0, 19) == 0) ? 21'($urandom_range(1, 21'h1FFFFF))
				: letter());
		send_char(21'd0);
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		calm = 0;
		hold_req = 0;
		items_sent = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: anchored class loop with captures, every opcode present
		set_regs(10, 0, 16);
		load_word(0, OP_SAVE, 0, 0, 0, 0, 0);
		load_word(1, OP_BOL, 0, 0, 0, 0, 0);
		load_word(2, OP_SAVE, 0, 0, 0, 0, 1);
		load_word(3, OP_CLASS, 21'h61, 21'h63, 5, 0, 0);
		load_word(4, OP_CLASS, 21'h78, 21'h1FFFFF, 5, 0, 0);
		load_word(5, OP_SPLIT, 0, 0, 3, 6, 0);
		load_word(6, OP_UNSAVE, 0, 0, 0, 0, 1);
		load_word(7, OP_NOTNL, 0, 0, 0, 0, 0);
		load_word(8, OP_SAVE, 0, 0, 0, 0, 12);
		load_word(9, OP_EOL, 0, 0, 0, 0, 0);
		load_word(10, OP_UNSAVE, 0, 0, 0, 0, 0);
		load_word(11, OP_JMP, 0, 0, 13, 0, 0);
		load_word(12, 4'd15, 0, 0, 0, 0, 0);
		load_word(13, OP_RUNE, 21'h10FFFF, 0, 0, 0, 0);
		load_word(14, OP_ANY, 0, 0, 0, 0, 0);
		load_word(15, OP_UNSAVE, 0, 0, 0, 0, 0);
		send_char(21'h61);
		send_char(21'h62);
		send_char(21'd0);
		send_char(NEWLINE);
		send_char(21'h7A);
		send_char(21'd0);
		send_char(21'h1FFFFF);
		send_char(21'd0);
		settle();
		set_regs(3, 11, 16);
		send_char(21'h10FFFF);
		send_char(21'h71);
		send_char(21'h71);
		send_char(21'd0);

		for (int phase = 0; phase < 4 || items_sent < 100; phase++) begin
			settle();
			calm = (phase == 2);
			case (phase)
				0: begin
					set_regs(0, 0, 1);
					random_program(1);
				end
				1: begin
					set_regs(10, 0, 4);
					load_word(0, OP_SAVE, 0, 0, 0, 0, 0);
					load_word(1, OP_ANY, 0, 0, 0, 0, 0);
					load_word(2, OP_UNSAVE, 0, 0, 0, 0, 0);
					load_word(3, OP_ANY, 0, 0, 0, 0, 0);
					hold_req = 1;
					for (int i = 0; i < 4; i++) begin
						send_char(letter());
						send_char(21'd0);
					end
				end
				2: begin
					// a chain of splits that needs more threads than the pool holds
					set_regs(2, 0, 33);
					for (int a = 0; a < 32; a++)
						load_word(a, OP_SPLIT, 0, 0, 8'(a + 1), 8'(a + 1), 0);
					load_word(32, OP_UNSAVE, 0, 0, 0, 0, 0);
					send_char(21'h61);
					send_char(21'd0);
				end
				3: begin
					set_regs(15, 255, 9'h1FF);
					load_word(255, OP_ANY, 0, 0, 0, 0, 0);
					send_char(21'h61);
					send_char(21'h61);
					send_char(21'd0);
				end
				default: begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
						: $urandom_range(4, 14);
					set_regs($urandom_range(0, 15),
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
							: $urandom_range(0, len - 1), len);
					random_program(len);
				end
			endcase
			repeat ($urandom_range(1, 2)) random_text();
		end
		calm = 0;
		settle();
		if (errors == 0 && outstanding == 0)
			$display("** pike_vm_regex_matcher: PASSED **");
		else
			$display("** pike_vm_regex_matcher: FAILED **");
		$finish;
	end

endmodule

/* pike_vm_regex_matcher.f */
design/pvm_pkg.sv
design/pvm_ram.sv
design/pike_vm_regex_matcher.sv
test/pvm_checker.sv
test/tb.sv
